// ----- rtl/etk_pkg.sv -----
package etk_pkg;

    localparam int VALUE_BITS = 63;
    localparam int NUM_W      = 63;
    localparam int SYM_W      = 8;
    localparam int QUEUE_DEPTH = 4;
    localparam int PTR_W      = $clog2(QUEUE_DEPTH);
    localparam int CNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [VALUE_BITS-1:0] VALUE_MAX = '1;

    typedef enum logic [1:0] {
        KIND_NUMBER      = 2'd0,
        KIND_OPERATOR    = 2'd1,
        KIND_UNSUPPORTED = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        CLS_DIGIT,
        CLS_SKIP,
        CLS_OPERATOR,
        CLS_UNSUPPORTED
    } char_class_t;

    typedef struct packed {
        kind_t              kind;
        logic [NUM_W-1:0]   number_value;
        logic [SYM_W-1:0]   symbol;
        logic               overflowed;
        logic               last_of_run;
    } result_t;

    // Results produced by one accepted item, in order r0 then r1.
    typedef struct packed {
        logic [1:0] count;
        result_t    r0;
        result_t    r1;
    } push_t;

    function automatic char_class_t classify(input logic [7:0] c);
        char_class_t cls;
        if (c >= 8'd48 && c <= 8'd57) begin
            cls = CLS_DIGIT;
        end else if ((c >= 8'd9 && c <= 8'd13) || c == 8'd32 ||
                     (c >= 8'd65 && c <= 8'd90) || (c >= 8'd97 && c <= 8'd122)) begin
            cls = CLS_SKIP;
        end else if ((c >= 8'd33 && c <= 8'd47) || (c >= 8'd58 && c <= 8'd64) ||
                     (c >= 8'd91 && c <= 8'd96) || (c >= 8'd123 && c <= 8'd126)) begin
            cls = CLS_OPERATOR;
        end else begin
            cls = CLS_UNSUPPORTED;
        end
        return cls;
    endfunction

endpackage

// ----- rtl/etk_core.sv -----
module etk_core import etk_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_fire,
    input  logic [7:0]       ch,
    input  logic             end_of_text,
    output push_t            push
);

    localparam int AW = VALUE_BITS + 4;

    logic                  in_number_reg, in_number_next;
    logic [VALUE_BITS-1:0] acc_reg, acc_next;
    logic                  sticky_reg, sticky_next;

    char_class_t           cls;
    logic [3:0]            digit;
    logic [AW-1:0]         acc_wide;
    logic [AW-1:0]         mul;
    logic                  step_ovf;
    logic [VALUE_BITS-1:0] acc_new;
    logic                  sticky_new;
    result_t               num_res;
    result_t               sym_res;

    assign cls      = classify(ch);
    assign digit    = 4'(ch - 8'd48);
    assign acc_wide = AW'(acc_reg);
    // value*10 + digit as two shifts and two adds; any bit above the value width means overflow.
    assign mul      = (acc_wide << 3) + (acc_wide << 1) + AW'(digit);
    assign step_ovf = |mul[AW-1:VALUE_BITS];

    always_comb begin
        if (!in_number_reg) begin
            acc_new    = VALUE_BITS'(digit);
            sticky_new = 1'b0;
        end else if (step_ovf) begin
            acc_new    = VALUE_MAX;
            sticky_new = 1'b1;
        end else begin
            acc_new    = mul[VALUE_BITS-1:0];
            sticky_new = sticky_reg;
        end
    end

    always_comb begin
        num_res              = '0;
        num_res.kind         = KIND_NUMBER;
        sym_res              = '0;
        sym_res.symbol       = ch;
        sym_res.last_of_run  = 1'b1;
        sym_res.kind         = (cls == CLS_OPERATOR) ? KIND_OPERATOR : KIND_UNSUPPORTED;
        push                 = '0;

        if (cls == CLS_DIGIT) begin
            num_res.number_value = NUM_W'(acc_new);
            num_res.overflowed   = sticky_new;
            num_res.last_of_run  = 1'b1;
            if (end_of_text) begin
                push.count = 2'd1;
                push.r0    = num_res;
            end
        end else begin
            num_res.number_value = NUM_W'(acc_reg);
            num_res.overflowed   = sticky_reg;
            num_res.last_of_run  = (cls == CLS_SKIP);
            if (in_number_reg) begin
                push.r0 = num_res;
                if (cls == CLS_SKIP) begin
                    push.count = 2'd1;
                end else begin
                    push.count = 2'd2;
                    push.r1    = sym_res;
                end
            end else if (cls != CLS_SKIP) begin
                push.count = 2'd1;
                push.r0    = sym_res;
            end
        end

        if (!in_fire) begin
            push.count = 2'd0;
        end
    end

    always_comb begin
        in_number_next = in_number_reg;
        acc_next       = acc_reg;
        sticky_next    = sticky_reg;
        if (in_fire) begin
            if (end_of_text || cls != CLS_DIGIT) begin
                in_number_next = 1'b0;
                acc_next       = '0;
                sticky_next    = 1'b0;
            end else begin
                in_number_next = 1'b1;
                acc_next       = acc_new;
                sticky_next    = sticky_new;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_number_reg <= 1'b0;
            acc_reg       <= '0;
            sticky_reg    <= 1'b0;
        end else begin
            in_number_reg <= in_number_next;
            acc_reg       <= acc_next;
            sticky_reg    <= sticky_next;
        end
    end

    a_idle_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        !in_number_reg |-> (acc_reg == '0 && !sticky_reg))
        else $error("accumulator not cleared outside a number");

    a_pair_order: assert property (@(posedge aclk) disable iff (!aresetn)
        push.count == 2'd2 |-> (push.r0.kind == KIND_NUMBER && !push.r0.last_of_run &&
                                push.r1.last_of_run))
        else $error("two results must be number then symbol");

    a_number_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_fire && cls == CLS_DIGIT && !end_of_text) |=> in_number_reg)
        else $error("digit did not open a number");

endmodule

// ----- rtl/etk_queue.sv -----
module etk_queue import etk_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  push_t    push,
    output logic     room,
    output logic     out_valid,
    input  logic     out_ready,
    output result_t  out_res
);

    result_t             mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]    wptr_reg, wptr_next;
    logic [PTR_W-1:0]    rptr_reg, rptr_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic                pop;
    logic [PTR_W-1:0]    wptr_plus1;

    assign pop        = out_valid && out_ready;
    assign out_valid  = (count_reg != '0);
    assign out_res    = mem[rptr_reg];
    // Room is kept for the worst case of two results from the next item.
    assign room       = (count_reg <= CNT_W'(QUEUE_DEPTH - 2));
    assign wptr_plus1 = wptr_reg + PTR_W'(1);

    always_comb begin
        wptr_next  = wptr_reg + PTR_W'(push.count);
        rptr_next  = rptr_reg + PTR_W'(pop);
        count_next = count_reg + CNT_W'(push.count) - CNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (push.count != 2'd0) begin
            mem[wptr_reg] <= push.r0;
        end
        if (push.count == 2'd2) begin
            mem[wptr_plus1] <= push.r1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end else begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    a_no_overfill: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("result queue overfilled");

    a_push_room: assert property (@(posedge aclk) disable iff (!aresetn)
        push.count != 2'd0 |-> count_reg <= CNT_W'(QUEUE_DEPTH - 2))
        else $error("push without room");

    a_pop_only: assert property (@(posedge aclk) disable iff (!aresetn)
        (pop && push.count == 2'd0) |=> count_reg == $past(count_reg) - CNT_W'(1))
        else $error("pop did not reduce fill");

endmodule

// ----- rtl/expression_tokenizer.sv -----
// A result appears on the m_ side in the cycle after the item that causes it is accepted,
// when the result queue is empty; a second result of the same item follows once the first
// is taken. Throughput: one item per cycle while the queue has room; the m_ side moves
// one result per cycle, while m_tready is high, from a 4-entry queue.
// Reset: aresetn is synchronous, active low; it clears the number state and empties the queue.
module expression_tokenizer import etk_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] ch
    input  logic        s_tlast,   // end_of_text
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // [62:0] number_value, [70:63] symbol, [71] overflowed
    output logic [1:0]  m_tuser,   // [1:0] kind
    output logic        m_tlast    // last_of_run
);

    logic    in_fire;
    push_t   push;
    result_t head;

    assign in_fire = s_tvalid && s_tready;

    etk_core u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_fire     (in_fire),
        .ch          (s_tdata),
        .end_of_text (s_tlast),
        .push        (push)
    );

    etk_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .room      (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (head)
    );

    assign m_tdata = {head.overflowed, head.symbol, head.number_value};
    assign m_tuser = head.kind;
    assign m_tlast = head.last_of_run;

endmodule

// ----- tb/sv/tb_top.sv -----
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import etk_pkg::*;

    localparam int  SCORED_ITEMS = 900;
    localparam int  CALM_FROM    = 780;
    localparam int  STALL_LIMIT  = 1000;
    localparam int  DRAIN_CYCLES = 10;
    localparam logic [NUM_W-1:0] NUM_TOP = '1;
    localparam result_t NO_TOK = '0;

    typedef enum int {
        BC_DIGIT,
        BC_SPACE,
        BC_LETTER,
        BC_OP,
        BC_ODD
    } byte_cls_t;

    typedef struct {
        logic [7:0] ch;
        logic       eot;
        int         rep;
        bit         typed;
        int         n;
        result_t    r0;
        result_t    r1;
    } text_row_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = '0;   // [7:0] ch
    logic        s_tlast  = 1'b0; // end_of_text
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [71:0] m_tdata;         // [62:0] number_value, [70:63] symbol, [71] overflowed
    logic [1:0]  m_tuser;         // [1:0] kind
    logic        m_tlast;         // last_of_run

    // Lexer state mirrored by the predictor.
    logic             lx_in_number = 1'b0;
    logic [NUM_W-1:0] lx_acc       = '0;
    logic             lx_sticky    = 1'b0;

    result_t tokens_due[$];
    bit      idle_on = 1'b1;
    int      mismatches = 0;
    int      n_items = 0;
    int      n_texts = 0;
    int      n_numbers = 0;
    int      n_saturated = 0;
    int      n_ops = 0;
    int      n_odd = 0;
    int      stall_left = 0;
    int      quiet_cycles = 0;

    expression_tokenizer u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic bit is_blank(input logic [7:0] c);
        return (c >= 8'd9 && c <= 8'd13) || c == 8'd32 ||
               (c >= 8'd65 && c <= 8'd90) || (c >= 8'd97 && c <= 8'd122);
    endfunction

    function automatic bit is_op(input logic [7:0] c);
        return (c >= 8'd33 && c <= 8'd47) || (c >= 8'd58 && c <= 8'd64) ||
               (c >= 8'd91 && c <= 8'd96) || (c >= 8'd123 && c <= 8'd126);
    endfunction

    function automatic result_t tok(input kind_t k, input logic [NUM_W-1:0] v,
                                    input logic [7:0] s, input logic o, input logic l);
        result_t r;
        r.kind         = k;
        r.number_value = v;
        r.symbol       = s;
        r.overflowed   = o;
        r.last_of_run  = l;
        return r;
    endfunction

    function automatic text_row_t row(input logic [7:0] c, input logic e, input int rep,
                                      input bit typed, input int n,
                                      input result_t a, input result_t b);
        text_row_t t;
        t.ch    = c;
        t.eot   = e;
        t.rep   = rep;
        t.typed = typed;
        t.n     = n;
        t.r0    = a;
        t.r1    = b;
        return t;
    endfunction

    // Steps the lexer by one byte and returns the tokens it emits, oldest first.
    function automatic int lex_byte(input logic [7:0] c, input logic e,
                                    output result_t r0, output result_t r1);
        result_t     toks[2];
        logic [63:0] d;
        logic [63:0] lim;
        int          n;
        n = 0;
        toks[0] = NO_TOK;
        toks[1] = NO_TOK;
        if (c >= 8'd48 && c <= 8'd57) begin
            d = 64'(c - 8'd48);
            if (!lx_in_number) begin
                lx_in_number = 1'b1;
                lx_sticky    = 1'b0;
                lx_acc       = d[NUM_W-1:0];
            end else begin
                lim = (64'(NUM_TOP) - d) / 64'd10;
                if (64'(lx_acc) > lim) begin
                    lx_acc    = NUM_TOP;
                    lx_sticky = 1'b1;
                end else begin
                    lx_acc = lx_acc * 63'd10 + d[NUM_W-1:0];
                end
            end
            if (e) begin
                toks[n] = tok(KIND_NUMBER, lx_acc, 8'd0, lx_sticky, 1'b0);
                n++;
            end
        end else begin
            if (lx_in_number) begin
                toks[n] = tok(KIND_NUMBER, lx_acc, 8'd0, lx_sticky, 1'b0);
                n++;
                lx_in_number = 1'b0;
                lx_acc       = '0;
                lx_sticky    = 1'b0;
            end
            if (!is_blank(c)) begin
                toks[n] = tok(is_op(c) ? KIND_OPERATOR : KIND_UNSUPPORTED, '0, c, 1'b0, 1'b0);
                n++;
            end
        end
        if (n > 0) begin
            toks[n-1].last_of_run = 1'b1;
        end
        if (e) begin
            lx_in_number = 1'b0;
            lx_acc       = '0;
            lx_sticky    = 1'b0;
        end
        r0 = toks[0];
        r1 = toks[1];
        return n;
    endfunction

    function automatic logic [7:0] pick_byte(input byte_cls_t k);
        logic [7:0] v;
        case (k)
            BC_DIGIT: begin
                v = 8'($urandom_range(48, 57));
            end
            BC_SPACE: begin
                v = 8'($urandom_range(9, 14));
                if (v == 8'd14) begin
                    v = 8'd32;
                end
            end
            BC_LETTER: begin
                v = $urandom_range(0, 1) ? 8'($urandom_range(65, 90))
                                         : 8'($urandom_range(97, 122));
            end
            BC_OP: begin
                do begin
                    v = 8'($urandom_range(33, 126));
                end while (!is_op(v));
            end
            default: begin
                case ($urandom_range(0, 2))
                    0:       v = 8'($urandom_range(0, 8));
                    1:       v = 8'($urandom_range(14, 31));
                    default: v = 8'($urandom_range(127, 255));
                endcase
            end
        endcase
        return v;
    endfunction

    // Presents one item, waits for it to be taken and queues the tokens it should cause.
    // A typed row overrides the predictor with the tokens written in the table.
    task automatic send_item(input logic [7:0] c, input logic e, input bit typed = 1'b0,
                             input int tn = 0, input result_t t0 = '0, input result_t t1 = '0);
        result_t p0;
        result_t p1;
        int      n;
        if (idle_on && $urandom_range(0, 7) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tlast  <= e;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        n = lex_byte(c, e, p0, p1);
        if (typed) begin
            n  = tn;
            p0 = t0;
            p1 = t1;
        end
        if (n > 0) begin
            tokens_due.insert(tokens_due.size(), p0);
        end
        if (n > 1) begin
            tokens_due.insert(tokens_due.size(), p1);
        end
        n_items++;
    endtask

    // Result side back-pressure in random bursts.
    always @(posedge aclk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end else if (idle_on && $urandom_range(0, 9) == 0) begin
            stall_left <= $urandom_range(0, 18);
            m_tready   <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Token checker and watchdog.
    always @(posedge aclk) begin
        result_t exp_tok;
        if (aresetn && m_tvalid && m_tready) begin
            if (tokens_due.size() == 0) begin
                $error("unexpected token: kind %0d value %0d symbol %0d",
                       m_tuser, m_tdata[62:0], m_tdata[70:63]);
                mismatches++;
            end else begin
                exp_tok = tokens_due.pop_front();
                if (m_tuser !== exp_tok.kind) begin
                    $error("kind: expected %0d, got %0d", exp_tok.kind, m_tuser);
                    mismatches++;
                end
                if (m_tdata[62:0] !== exp_tok.number_value) begin
                    $error("number_value: expected %0d, got %0d",
                           exp_tok.number_value, m_tdata[62:0]);
                    mismatches++;
                end
                if (m_tdata[70:63] !== exp_tok.symbol) begin
                    $error("symbol: expected %0d, got %0d", exp_tok.symbol, m_tdata[70:63]);
                    mismatches++;
                end
                if (m_tdata[71] !== exp_tok.overflowed) begin
                    $error("overflowed: expected %0d, got %0d", exp_tok.overflowed, m_tdata[71]);
                    mismatches++;
                end
                if (m_tlast !== exp_tok.last_of_run) begin
                    $error("last_of_run: expected %0d, got %0d", exp_tok.last_of_run, m_tlast);
                    mismatches++;
                end
                case (exp_tok.kind)
                    KIND_NUMBER: begin
                        n_numbers++;
                        if (exp_tok.overflowed) begin
                            n_saturated++;
                        end
                    end
                    KIND_OPERATOR: n_ops++;
                    default:       n_odd++;
                endcase
            end
        end
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $error("no progress for %0d cycles, %0d tokens outstanding",
                   STALL_LIMIT, tokens_due.size());
            $display("tb_top: done, errors");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        text_row_t  rows[$];
        logic [7:0] text[$];
        string      top_digits;
        int         ntok;
        int         len;
        int         pick;
        top_digits = "922337203685477580";

        rows.insert(rows.size(), row(8'd0,   1'b0, 1,  1, 1,
                    tok(KIND_UNSUPPORTED, '0, 8'd0, 1'b0, 1'b1), NO_TOK));
        rows.insert(rows.size(), row(8'd31,  1'b0, 1,  1, 1,
                    tok(KIND_UNSUPPORTED, '0, 8'd31, 1'b0, 1'b1), NO_TOK));
        rows.insert(rows.size(), row(8'd127, 1'b0, 1,  1, 1,
                    tok(KIND_UNSUPPORTED, '0, 8'd127, 1'b0, 1'b1), NO_TOK));
        rows.insert(rows.size(), row(8'd255, 1'b0, 1,  1, 1,
                    tok(KIND_UNSUPPORTED, '0, 8'd255, 1'b0, 1'b1), NO_TOK));
        rows.insert(rows.size(), row(8'd33,  1'b0, 1,  1, 1,
                    tok(KIND_OPERATOR, '0, 8'd33, 1'b0, 1'b1), NO_TOK));
        rows.insert(rows.size(), row(8'd58,  1'b0, 1,  1, 1,
                    tok(KIND_OPERATOR, '0, 8'd58, 1'b0, 1'b1), NO_TOK));
        rows.insert(rows.size(), row(8'd96,  1'b0, 1,  1, 1,
                    tok(KIND_OPERATOR, '0, 8'd96, 1'b0, 1'b1), NO_TOK));
        rows.insert(rows.size(), row(8'd126, 1'b0, 1,  1, 1,
                    tok(KIND_OPERATOR, '0, 8'd126, 1'b0, 1'b1), NO_TOK));
        rows.insert(rows.size(), row(8'd9,   1'b0, 1,  1, 0, NO_TOK, NO_TOK));
        rows.insert(rows.size(), row(8'd13,  1'b0, 1,  1, 0, NO_TOK, NO_TOK));
        rows.insert(rows.size(), row(8'd32,  1'b0, 1,  1, 0, NO_TOK, NO_TOK));
        rows.insert(rows.size(), row(8'd90,  1'b0, 1,  1, 0, NO_TOK, NO_TOK));
        // A symbol that closes a number: the number first, then the symbol.
        rows.insert(rows.size(), row(8'd49,  1'b0, 1,  1, 0, NO_TOK, NO_TOK));
        rows.insert(rows.size(), row(8'd50,  1'b0, 1,  1, 0, NO_TOK, NO_TOK));
        rows.insert(rows.size(), row(8'd42,  1'b0, 1,  1, 2,
                    tok(KIND_NUMBER, 63'd12, 8'd0, 1'b0, 1'b0),
                    tok(KIND_OPERATOR, '0, 8'd42, 1'b0, 1'b1)));
        // A digit carrying end of text flushes its number at once.
        rows.insert(rows.size(), row(8'd48,  1'b1, 1,  1, 1,
                    tok(KIND_NUMBER, 63'd0, 8'd0, 1'b0, 1'b1), NO_TOK));
        rows.insert(rows.size(), row(8'd52,  1'b0, 1,  0, 0, NO_TOK, NO_TOK));
        rows.insert(rows.size(), row(8'd48,  1'b0, 1,  0, 0, NO_TOK, NO_TOK));
        rows.insert(rows.size(), row(8'd53,  1'b0, 1,  0, 0, NO_TOK, NO_TOK));
        rows.insert(rows.size(), row(8'd32,  1'b1, 1,  0, 0, NO_TOK, NO_TOK));
        // Nineteen nines pass the largest value, so the number saturates.
        rows.insert(rows.size(), row(8'd57,  1'b0, 19, 1, 0, NO_TOK, NO_TOK));
        rows.insert(rows.size(), row(8'd59,  1'b1, 1,  1, 2,
                    tok(KIND_NUMBER, NUM_TOP, 8'd0, 1'b1, 1'b0),
                    tok(KIND_OPERATOR, '0, 8'd59, 1'b0, 1'b1)));
        rows.insert(rows.size(), row(8'd65,  1'b1, 1,  1, 0, NO_TOK, NO_TOK));

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (rows[i]) begin
            repeat (rows[i].rep) begin
                send_item(rows[i].ch, rows[i].eot, rows[i].typed,
                          rows[i].n, rows[i].r0, rows[i].r1);
            end
        end

        while (n_items < SCORED_ITEMS) begin
            idle_on = (n_items < CALM_FROM) && ($urandom_range(0, 3) != 0);
            n_texts++;
            if ($urandom_range(0, 6) == 0) begin
                // Raw bytes with an occasional end of text anywhere.
                repeat ($urandom_range(1, 6)) begin
                    send_item(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
                end
            end else begin
                text.delete();
                ntok = $urandom_range(1, 8);
                repeat (ntok) begin
                    pick = $urandom_range(0, 99);
                    if (pick < 45) begin
                        if ($urandom_range(0, 19) != 0) begin
                            repeat ($urandom_range(1, 5)) begin
                                text.insert(text.size(), pick_byte(BC_DIGIT));
                            end
                        end else if ($urandom_range(0, 1) == 0) begin
                            // Just below, at or just past the largest value.
                            for (int k = 0; k < top_digits.len(); k++) begin
                                text.insert(text.size(), top_digits[k]);
                            end
                            text.insert(text.size(), pick_byte(BC_DIGIT));
                            if ($urandom_range(0, 3) == 0) begin
                                text.insert(text.size(), pick_byte(BC_DIGIT));
                            end
                        end else begin
                            len = $urandom_range(17, 22);
                            repeat (len) text.insert(text.size(), pick_byte(BC_DIGIT));
                        end
                    end else if (pick < 70) begin
                        text.insert(text.size(), pick_byte(BC_OP));
                    end else if (pick < 85) begin
                        repeat ($urandom_range(1, 2)) begin
                            text.insert(text.size(), pick_byte(BC_SPACE));
                        end
                    end else if (pick < 95) begin
                        text.insert(text.size(), pick_byte(BC_LETTER));
                    end else begin
                        text.insert(text.size(), pick_byte(BC_ODD));
                    end
                end
                foreach (text[k]) begin
                    send_item(text[k], k == text.size() - 1);
                end
            end
        end

        s_tvalid <= 1'b0;
        idle_on = 1'b0;
        while (tokens_due.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("tb_top: %0d bytes in %0d texts plus a directed table", n_items, n_texts);
        $display("tb_top: tokens seen: %0d numbers (%0d saturated), %0d operators, %0d unsupported",
                 n_numbers, n_saturated, n_ops, n_odd);
        if (mismatches == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/etk_pkg.sv
rtl/etk_core.sv
rtl/etk_queue.sv
rtl/expression_tokenizer.sv
tb/sv/tb_top.sv
